// ===== rtl/mmgn_pkg.sv =====
package mmgn_pkg;

  // Sample and result widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int GREY_W       = 8;

  // Widths of the scaling datapath
  localparam int SPAN_W = SAMPLE_WIDTH + 1;   // max - min, and sample - min
  localparam int NUM_W  = SPAN_W + GREY_W;    // 255 * (sample - min)
  localparam int DIV_W  = NUM_W + 2;          // 2*num + span, and 2*span shifted
  localparam int QUO_W  = GREY_W + 1;         // quotient bits produced by the divider
  localparam int STEP_W = $clog2(QUO_W);      // divider step counter

  // Reset values of the running extremes
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [GREY_W-1:0] GREY_FULL = {GREY_W{1'b1}};
  localparam logic [GREY_W-1:0] GREY_ZERO = '0;

  // Item commands
  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_SCALE   = 2'd2
  } cmd_t;

endpackage

// ===== rtl/minmax_grey_normalizer_top.sv =====
// Min-max grey normaliser. Each item carries a command and a signed sample:
// restart returns the stored extremes to their reset values (minimum at the
// most positive, maximum at the most negative sample), measure folds the
// sample into the minimum and maximum, and scale returns
// grey = round(255 * (sample - min) / (max - min)), rounding half up, clamped
// to 0..255, and 0 when max <= min. Every item gives exactly one result with
// the grey level (0 unless scaling) and the extremes as they stand after it.
// One item is worked on at a time. Restart, measure, unused commands and
// out-of-range scales go straight from the execute to the done state; an
// in-range scale passes the prepare and divide states, where the nine-step
// restoring divider forms the rounded quotient. The next item can be
// accepted from the cycle after the result is loaded. A result waits in
// the output register while the next item is accepted.
module minmax_grey_normalizer_top (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [1:0]                                command,
  input  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  sample,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [mmgn_pkg::GREY_W-1:0]               grey_level,
  output logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  lowest_seen,
  output logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  highest_seen
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t                                   state;
  logic [1:0]                               cmd;
  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0] val;
  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0] lo;
  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0] hi;
  logic [mmgn_pkg::SPAN_W-1:0]              diff;
  logic [mmgn_pkg::SPAN_W-1:0]              span;
  logic [mmgn_pkg::GREY_W-1:0]              grey;

  logic [mmgn_pkg::SPAN_W-1:0]              diff_next;
  logic [mmgn_pkg::SPAN_W-1:0]              span_next;
  logic [mmgn_pkg::NUM_W-1:0]               num;
  logic [mmgn_pkg::DIV_W-1:0]               dividend;
  logic [mmgn_pkg::DIV_W-1:0]               divisor;
  logic                                     div_start;
  logic                                     div_done;
  logic [mmgn_pkg::QUO_W-1:0]               quotient;
  logic                                     out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Offsets from the minimum, widened by one bit
  assign diff_next = mmgn_pkg::SPAN_W'({val[mmgn_pkg::SAMPLE_WIDTH-1], val}
                                      - {lo[mmgn_pkg::SAMPLE_WIDTH-1], lo});
  assign span_next = mmgn_pkg::SPAN_W'({hi[mmgn_pkg::SAMPLE_WIDTH-1], hi}
                                      - {lo[mmgn_pkg::SAMPLE_WIDTH-1], lo});

  // Rounding divide operands: (2*255*diff + span) / (2*span)
  always_comb begin
    num      = (mmgn_pkg::NUM_W'(diff) << mmgn_pkg::GREY_W) - mmgn_pkg::NUM_W'(diff);
    dividend = {1'b0, num, 1'b0} + mmgn_pkg::DIV_W'(span);
    divisor  = mmgn_pkg::DIV_W'({span, 1'b0});
  end

  assign div_start = (state == S_PREP);

  mmgn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer, extremes and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lo        <= mmgn_pkg::SAMPLE_MAX;
      hi        <= mmgn_pkg::SAMPLE_MIN;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            val   <= sample;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          priority if (cmd == mmgn_pkg::CMD_RESTART) begin
            lo    <= mmgn_pkg::SAMPLE_MAX;
            hi    <= mmgn_pkg::SAMPLE_MIN;
            grey  <= mmgn_pkg::GREY_ZERO;
            state <= S_DONE;
          end else if (cmd == mmgn_pkg::CMD_MEASURE) begin
            if (val > hi) begin
              hi <= val;
            end
            if (val < lo) begin
              lo <= val;
            end
            grey  <= mmgn_pkg::GREY_ZERO;
            state <= S_DONE;
          end else if (cmd == mmgn_pkg::CMD_SCALE) begin
            priority if (hi <= lo || val <= lo) begin
              grey  <= mmgn_pkg::GREY_ZERO;
              state <= S_DONE;
            end else if (val >= hi) begin
              grey  <= mmgn_pkg::GREY_FULL;
              state <= S_DONE;
            end else begin
              diff  <= diff_next;
              span  <= span_next;
              state <= S_PREP;
            end
          end else begin
            // unused command: report the extremes unchanged
            grey  <= mmgn_pkg::GREY_ZERO;
            state <= S_DONE;
          end
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            grey  <= quotient[mmgn_pkg::GREY_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            grey_level   <= grey;
            lowest_seen  <= lo;
            highest_seen <= hi;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mmgn_div.sv =====
module mmgn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mmgn_pkg::DIV_W-1:0]    dividend,
  input  logic [mmgn_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [mmgn_pkg::QUO_W-1:0]    quotient
);

  logic                          running;
  logic [mmgn_pkg::STEP_W-1:0]   step;
  logic [mmgn_pkg::DIV_W-1:0]    rem;
  logic [mmgn_pkg::DIV_W-1:0]    dvs;
  logic                          fits;

  // One trial subtraction per cycle
  assign fits = (rem >= dvs);

  // Restoring divide, most significant quotient bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        rem      <= dividend;
        dvs      <= divisor << (mmgn_pkg::QUO_W - 1);
        quotient <= '0;
      end else if (running) begin
        if (fits) begin
          rem <= rem - dvs;
        end
        quotient <= {quotient[mmgn_pkg::QUO_W-2:0], fits};
        dvs      <= dvs >> 1;
        step     <= step + 1'b1;
        if (step == mmgn_pkg::STEP_W'(mmgn_pkg::QUO_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mmgn_checker.sv =====
module mmgn_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  logic                                      in_ready,
  input  logic [1:0]                                command,
  input  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  sample,
  input  logic                                      out_valid,
  input  logic                                      out_ready,
  input  logic [mmgn_pkg::GREY_W-1:0]               grey_level,
  input  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  lowest_seen,
  input  logic signed [mmgn_pkg::SAMPLE_WIDTH-1:0]  highest_seen
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grey_level)
      && $stable(lowest_seen) && $stable(highest_seen))
    else $error("result changed while stalled");

  // One item at a time: no acceptance straight after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // Extremes are either ordered or both at their reset values
  a_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lowest_seen <= highest_seen)
      || (lowest_seen == mmgn_pkg::SAMPLE_MAX && highest_seen == mmgn_pkg::SAMPLE_MIN))
    else $error("stored extremes inconsistent");

  // A grey level above zero needs a non-empty range
  a_grey_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && grey_level != mmgn_pkg::GREY_ZERO |-> highest_seen > lowest_seen)
    else $error("grey level given for an empty range");

  // A presented result carries fully known fields
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({grey_level, lowest_seen, highest_seen}))
    else $error("result presented with unknown fields");

endmodule

bind minmax_grey_normalizer_top mmgn_checker u_mmgn_checker (.*);
